>>> rtl/tiled_matrix_multiply_mod_assert.svh
// Assertion macros for the RTL; tmm_ctrl is the file that includes them.
`ifndef TILED_MATRIX_MULTIPLY_MOD_ASSERT_SVH
`define TILED_MATRIX_MULTIPLY_MOD_ASSERT_SVH
// Implication check, disabled during reset.
`define TMM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication check, disabled during reset.
`define TMM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/tmm_pkg.sv
// ----------------------------------------------------------------------------
// tmm_pkg
// Types and constants of the tiled matrix multiply block.
// ----------------------------------------------------------------------------
package tmm_pkg;
  localparam int Dim      = 128;
  localparam int Tile     = 4;
  localparam int ElemBits = 10;
  localparam int IdxBits  = 7;
  localparam int KBits    = $clog2(Dim);
  localparam int TBits    = $clog2(Tile);
  localparam int NElem    = Tile * Tile;
  localparam int EBits    = $clog2(NElem);
  localparam int AddrBits = 2 * KBits;

  typedef enum logic [1:0] {
    OP_WR_A = 2'd0,
    OP_WR_B = 2'd1,
    OP_TILE = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ACC,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic              in_ready;  // accept input word
    logic              clear;     // zero accumulators
    logic              acc_en;    // issue read at k
    logic [KBits-1:0]  k;
    logic              out_valid;
    logic [EBits-1:0]  elem;      // element under output
  } cmd_t;
endpackage

>>> rtl/tmm_if.sv
// ----------------------------------------------------------------------------
// tmm_in_if / tmm_out_if
// Valid/ready channels for request and result words.
// ----------------------------------------------------------------------------
interface tmm_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                op;
  logic [tmm_pkg::IdxBits-1:0] row;
  logic [tmm_pkg::IdxBits-1:0] col;
  logic [tmm_pkg::ElemBits-1:0] value;
  modport source (output valid, op, row, col, value, input ready);
  modport sink   (input valid, op, row, col, value, output ready);
endinterface

interface tmm_out_if;
  logic                      valid;
  logic                      ready;
  logic [tmm_pkg::IdxBits-1:0] out_row;
  logic [tmm_pkg::IdxBits-1:0] out_col;
  logic [tmm_pkg::ElemBits-1:0] product;
  logic                      last;
  modport source (output valid, out_row, out_col, product, last, input ready);
  modport sink   (input valid, out_row, out_col, product, last, output ready);
endinterface

>>> rtl/tmm_ctrl.sv
// ----------------------------------------------------------------------------
// tmm_ctrl
// Sequencer: walks the inner dimension, then streams the tile out.
// ----------------------------------------------------------------------------
`include "tiled_matrix_multiply_mod_assert.svh"
module tmm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     in_op_i,
  input  logic           out_ready_i,
  output tmm_pkg::cmd_t  cmd_o
);
  tmm_pkg::state_e state_q, state_d;
  logic [tmm_pkg::KBits-1:0] k_q, k_d;
  logic [tmm_pkg::EBits-1:0] e_q, e_d;
  logic [1:0] drain_q, drain_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tmm_pkg::ST_IDLE;
      k_q <= '0;
      e_q <= '0;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      k_q <= k_d;
      e_q <= e_d;
      drain_q <= drain_d;
    end
  end

  always_comb begin
    state_d = state_q;
    k_d = k_q;
    e_d = e_q;
    drain_d = drain_q;
    unique case (state_q)
      tmm_pkg::ST_IDLE: begin
        if (in_valid_i && in_op_i == tmm_pkg::OP_TILE) state_d = tmm_pkg::ST_CLEAR;
      end
      tmm_pkg::ST_CLEAR: begin
        k_d = '0;
        state_d = tmm_pkg::ST_ACC;
      end
      tmm_pkg::ST_ACC: begin
        k_d = k_q + 1'b1;
        if (k_q == tmm_pkg::KBits'(tmm_pkg::Dim - 1)) begin
          drain_d = '0;
          state_d = tmm_pkg::ST_DRAIN;
        end
      end
      tmm_pkg::ST_DRAIN: begin
        // read latency plus multiply stage
        drain_d = drain_q + 1'b1;
        if (drain_q == 2'd2) begin
          e_d = '0;
          state_d = tmm_pkg::ST_EMIT;
        end
      end
      tmm_pkg::ST_EMIT: begin
        if (out_ready_i) begin
          e_d = e_q + 1'b1;
          if (e_q == tmm_pkg::EBits'(tmm_pkg::NElem - 1)) state_d = tmm_pkg::ST_IDLE;
        end
      end
      default: state_d = tmm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.k = k_q;
    cmd_o.elem = e_q;
    unique case (state_q)
      tmm_pkg::ST_IDLE:  cmd_o.in_ready = 1'b1;
      tmm_pkg::ST_CLEAR: cmd_o.clear = 1'b1;
      tmm_pkg::ST_ACC:   cmd_o.acc_en = 1'b1;
      tmm_pkg::ST_DRAIN: cmd_o.acc_en = 1'b0;
      tmm_pkg::ST_EMIT:  cmd_o.out_valid = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  `TMM_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, cmd_o.in_ready, !cmd_o.out_valid && !cmd_o.acc_en)
  `TMM_ASSERT_NXT(a_tile_start, clk_i, rst_ni, cmd_o.in_ready && in_valid_i && in_op_i == tmm_pkg::OP_TILE, cmd_o.clear)
  `TMM_ASSERT_NXT(a_acc_end, clk_i, rst_ni, cmd_o.acc_en && k_q == tmm_pkg::KBits'(tmm_pkg::Dim - 1), state_q == tmm_pkg::ST_DRAIN)
endmodule

>>> rtl/tmm_datapath.sv
// ----------------------------------------------------------------------------
// tmm_datapath
// Matrix stores (an A column slice and a B row slice read per step),
// TILE x TILE multiply-accumulate array and output select.
// ----------------------------------------------------------------------------
module tmm_datapath (
  input  logic                          clk_i,
  input  tmm_pkg::cmd_t                 cmd_i,
  input  logic                          in_fire_i,
  input  logic [1:0]                    op_i,
  input  logic [tmm_pkg::IdxBits-1:0]   row_i,
  input  logic [tmm_pkg::IdxBits-1:0]   col_i,
  input  logic [tmm_pkg::ElemBits-1:0]  value_i,
  output logic [tmm_pkg::IdxBits-1:0]   out_row_o,
  output logic [tmm_pkg::IdxBits-1:0]   out_col_o,
  output logic [tmm_pkg::ElemBits-1:0]  product_o,
  output logic                          last_o
);
  localparam int T = tmm_pkg::Tile;
  localparam int D = tmm_pkg::Dim;
  localparam int EB = tmm_pkg::ElemBits;
  localparam int KB = tmm_pkg::KBits;
  localparam int TB = tmm_pkg::TBits;
  localparam int BankD = D * D / T;
  localparam int BankA = $clog2(BankD);

  // A banked by row mod T, B banked by column mod T
  logic [EB-1:0] mem_a [T][BankD];
  logic [EB-1:0] mem_b [T][BankD];
  logic [EB-1:0] rd_a_q [T];
  logic [EB-1:0] rd_b_q [T];
  logic [EB-1:0] prod_q [T][T];
  logic [EB-1:0] acc_q [T][T];
  logic          rd_v_q, prod_v_q;
  logic [tmm_pkg::IdxBits-1:0] top_q, left_q;

  logic [TB-1:0]    wr_bank_a, wr_bank_b;
  logic [BankA-1:0] wr_addr_a, wr_addr_b;
  assign wr_bank_a = row_i[TB-1:0];
  assign wr_addr_a = {row_i[KB-1:TB], col_i[KB-1:0]};
  assign wr_bank_b = col_i[TB-1:0];
  assign wr_addr_b = {col_i[KB-1:TB], row_i[KB-1:0]};

  for (genvar b = 0; b < T; b++) begin : g_bank
    always_ff @(posedge clk_i) begin
      if (in_fire_i && op_i == tmm_pkg::OP_WR_A && wr_bank_a == TB'(b))
        mem_a[b][wr_addr_a] <= value_i;
      if (in_fire_i && op_i == tmm_pkg::OP_WR_B && wr_bank_b == TB'(b))
        mem_b[b][wr_addr_b] <= value_i;
      rd_a_q[b] <= mem_a[b][{top_q[KB-1:TB], cmd_i.k}];
      rd_b_q[b] <= mem_b[b][{left_q[KB-1:TB], cmd_i.k}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      top_q  <= {row_i[tmm_pkg::IdxBits-1:TB], TB'(0)};
      left_q <= {col_i[tmm_pkg::IdxBits-1:TB], TB'(0)};
    end
    rd_v_q <= cmd_i.acc_en;
    prod_v_q <= rd_v_q;
  end

  for (genvar i = 0; i < T; i++) begin : g_r
    for (genvar j = 0; j < T; j++) begin : g_c
      logic [2*EB-1:0] m;
      assign m = rd_a_q[i] * rd_b_q[j];
      always_ff @(posedge clk_i) begin
        prod_q[i][j] <= m[EB-1:0];
        if (cmd_i.clear) acc_q[i][j] <= '0;
        else if (prod_v_q) acc_q[i][j] <= acc_q[i][j] + prod_q[i][j];
      end
    end
  end

  logic [TB-1:0] ei, ej;
  assign ei = cmd_i.elem[2*TB-1:TB];
  assign ej = cmd_i.elem[TB-1:0];
  assign out_row_o = top_q + tmm_pkg::IdxBits'(ei);
  assign out_col_o = left_q + tmm_pkg::IdxBits'(ej);
  assign product_o = acc_q[ei][ej];
  assign last_o = cmd_i.elem == tmm_pkg::EBits'(tmm_pkg::NElem - 1);
endmodule

>>> rtl/tiled_matrix_multiply_mod.sv
// ----------------------------------------------------------------------------
// tiled_matrix_multiply_mod
// Tiled matrix multiply, results modulo 1024.
// ----------------------------------------------------------------------------
// Element writes are accepted while idle. A tile word clears the accumulators,
// walks the inner dimension (one banked memory read of an A column slice and a
// B row slice per step feeding a 4x4 MAC array), drains the read and multiply
// stages, then delivers its 16 result words, one per cycle while the sink is
// ready. One word is processed at a time.
module tiled_matrix_multiply_mod (
  input logic       clk_i,
  input logic       rst_ni,
  tmm_in_if.sink    in_if,
  tmm_out_if.source out_if
);
  tmm_pkg::cmd_t cmd;

  tmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_op_i    (in_if.op),
    .out_ready_i(out_if.ready),
    .cmd_o      (cmd)
  );

  tmm_datapath u_dp (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .in_fire_i (in_if.valid && cmd.in_ready),
    .op_i      (in_if.op),
    .row_i     (in_if.row),
    .col_i     (in_if.col),
    .value_i   (in_if.value),
    .out_row_o (out_if.out_row),
    .out_col_o (out_if.out_col),
    .product_o (out_if.product),
    .last_o    (out_if.last)
  );

  assign in_if.ready  = cmd.in_ready;
  assign out_if.valid = cmd.out_valid;
endmodule

>>> dv/tmm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tmm_checker
// Watches the request and result channels, keeps shadow copies of both
// matrices, predicts every tile and compares result words in order.
// ----------------------------------------------------------------------------
module tmm_checker (
  input  logic      clk_i,
  input  logic      rst_ni,
  tmm_in_if         in_mon,
  tmm_out_if        out_mon,
  output int        fail_cnt_o,
  output int        pending_o,
  output int        results_o
);
  typedef struct packed {
    logic [tmm_pkg::IdxBits-1:0]  out_row;
    logic [tmm_pkg::IdxBits-1:0]  out_col;
    logic [tmm_pkg::ElemBits-1:0] product;
    logic                         last;
  } prod_word_t;

  logic [tmm_pkg::ElemBits-1:0] a_shadow [0:tmm_pkg::Dim*tmm_pkg::Dim-1];
  logic [tmm_pkg::ElemBits-1:0] b_shadow [0:tmm_pkg::Dim*tmm_pkg::Dim-1];
  prod_word_t                   tile_q[$];

  initial begin
    fail_cnt_o = 0;
    results_o  = 0;
  end

  assign pending_o = tile_q.size();

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    fail_cnt_o++;
  endtask

  // Push the 16 words of one tile, row-major, last flagged.
  task automatic predict_tile(input logic [tmm_pkg::IdxBits-1:0] row,
                              input logic [tmm_pkg::IdxBits-1:0] col);
    logic [tmm_pkg::IdxBits-1:0]  top;
    logic [tmm_pkg::IdxBits-1:0]  lft;
    logic [tmm_pkg::ElemBits-1:0] acc;
    prod_word_t                   w;
    top = {row[tmm_pkg::IdxBits-1:tmm_pkg::TBits], {tmm_pkg::TBits{1'b0}}};
    lft = {col[tmm_pkg::IdxBits-1:tmm_pkg::TBits], {tmm_pkg::TBits{1'b0}}};
    for (int i = 0; i < tmm_pkg::Tile; i++) begin
      for (int j = 0; j < tmm_pkg::Tile; j++) begin
        acc = '0;
        for (int k = 0; k < tmm_pkg::Dim; k++) begin
          acc = acc + a_shadow[(top + i) * tmm_pkg::Dim + k]
                    * b_shadow[k * tmm_pkg::Dim + lft + j];
        end
        w.out_row = top + tmm_pkg::IdxBits'(i);
        w.out_col = lft + tmm_pkg::IdxBits'(j);
        w.product = acc;
        w.last    = (i == tmm_pkg::Tile - 1) && (j == tmm_pkg::Tile - 1);
        tile_q.push_back(w);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_mon.valid && in_mon.ready) begin
      case (tmm_pkg::op_e'(in_mon.op))
        tmm_pkg::OP_WR_A: a_shadow[in_mon.row * tmm_pkg::Dim + in_mon.col] = in_mon.value;
        tmm_pkg::OP_WR_B: b_shadow[in_mon.row * tmm_pkg::Dim + in_mon.col] = in_mon.value;
        tmm_pkg::OP_TILE: predict_tile(in_mon.row, in_mon.col);
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    prod_word_t w;
    if (rst_ni && out_mon.valid && out_mon.ready) begin
      results_o++;
      if (tile_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word row %0d col %0d",
                                  out_mon.out_row, out_mon.out_col));
      end else begin
        w = tile_q.pop_front();
        if (out_mon.out_row !== w.out_row)
          report_mismatch($sformatf("out_row %0d, want %0d", out_mon.out_row, w.out_row));
        if (out_mon.out_col !== w.out_col)
          report_mismatch($sformatf("out_col %0d, want %0d", out_mon.out_col, w.out_col));
        if (out_mon.product !== w.product)
          report_mismatch($sformatf("product at (%0d,%0d) %0d, want %0d",
                                    w.out_row, w.out_col, out_mon.product, w.product));
        if (out_mon.last !== w.last)
          report_mismatch($sformatf("last at (%0d,%0d) %0b, want %0b",
                                    w.out_row, w.out_col, out_mon.last, w.last));
      end
    end
  end
endmodule

>>> dv/tiled_matrix_multiply_mod_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tiled_matrix_multiply_mod_tb
// Loads both matrices in full, then drives directed and random element
// writes and tile requests with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tiled_matrix_multiply_mod_tb;
  localparam int IdleLimit = 4000;
  localparam int HoldLen   = 600;

  logic clk_i;
  logic rst_ni;
  int   fail_cnt;
  int   pending;
  int   results;
  int   idle_cycles;
  int   n_tiles;
  int   n_writes;
  bit   no_gaps;

  tmm_in_if  in_bus ();
  tmm_out_if out_bus ();

  tiled_matrix_multiply_mod u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  tmm_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .results_o  (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    in_bus.valid  = 1'b0;
    in_bus.op     = tmm_pkg::OP_NOP;
    in_bus.row    = '0;
    in_bus.col    = '0;
    in_bus.value  = '0;
    out_bus.ready = 1'b0;
  end

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(input tmm_pkg::op_e op, input int row, input int col,
                           input int value);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.op    <= op;
    in_bus.row   <= tmm_pkg::IdxBits'(row);
    in_bus.col   <= tmm_pkg::IdxBits'(col);
    in_bus.value <= tmm_pkg::ElemBits'(value);
    do @(posedge clk_i); while (!(in_bus.valid && in_bus.ready));
    @(negedge clk_i);
    if (op == tmm_pkg::OP_TILE) n_tiles++;
    else if (op != tmm_pkg::OP_NOP) n_writes++;
  endtask

  // Receiver: random stalls, and one long hold-off once results are flowing.
  initial begin
    int  stall;
    bit  held;
    stall = 0;
    held  = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && results >= 40) begin
        held  = 1;
        stall = HoldLen;
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        stall--;
      end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
        out_bus.ready <= 1'b0;
        stall = pick_gap();
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no accepted word on either channel.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no progress for %0d cycles, %0d words pending",
                 idle_cycles, pending);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int r;
    int row;
    int col;
    n_tiles  = 0;
    n_writes = 0;
    no_gaps  = 1;
    rst_ni   = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni   = 1'b1;
    @(negedge clk_i);

    // Preload every entry so no tile ever reads an unwritten one.
    for (int i = 0; i < tmm_pkg::Dim * tmm_pkg::Dim; i++)
      send_word(tmm_pkg::OP_WR_A, i / tmm_pkg::Dim, i % tmm_pkg::Dim,
                $urandom_range(0, 1023));
    for (int i = 0; i < tmm_pkg::Dim * tmm_pkg::Dim; i++)
      send_word(tmm_pkg::OP_WR_B, i / tmm_pkg::Dim, i % tmm_pkg::Dim,
                $urandom_range(0, 1023));
    no_gaps = 0;

    // Directed: value extremes at corners, tile origins with low bits set, nop.
    send_word(tmm_pkg::OP_WR_A, 0, 0, 1023);
    send_word(tmm_pkg::OP_WR_B, 0, 0, 1023);
    send_word(tmm_pkg::OP_WR_A, 127, 127, 0);
    send_word(tmm_pkg::OP_WR_B, 127, 127, 1023);
    send_word(tmm_pkg::OP_WR_A, 0, 127, 1023);
    send_word(tmm_pkg::OP_WR_B, 127, 0, 1023);
    send_word(tmm_pkg::OP_TILE, 0, 0, 0);
    send_word(tmm_pkg::OP_TILE, 3, 3, 1023);
    send_word(tmm_pkg::OP_TILE, 127, 127, 0);
    send_word(tmm_pkg::OP_TILE, 125, 2, 511);
    send_word(tmm_pkg::OP_NOP, 127, 127, 1023);
    send_word(tmm_pkg::OP_NOP, 0, 0, 0);
    send_word(tmm_pkg::OP_TILE, 0, 127, 0);
    // zero a whole A row so a row of products is exactly zero
    for (int k = 0; k < tmm_pkg::Dim; k++) send_word(tmm_pkg::OP_WR_A, 64, k, 0);
    send_word(tmm_pkg::OP_TILE, 66, 1, 0);

    // Sender waits for every expected word before going on.
    in_bus.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);

    for (int n = 0; n < 250; n++) begin
      r   = $urandom_range(0, 99);
      row = $urandom_range(0, 127);
      col = $urandom_range(0, 127);
      if (n % 50 == 0) no_gaps = ~no_gaps;
      if (r < 25)      send_word(tmm_pkg::OP_TILE, row, col, $urandom_range(0, 1023));
      else if (r < 58) send_word(tmm_pkg::OP_WR_A, row, col, $urandom_range(0, 1023));
      else if (r < 92) send_word(tmm_pkg::OP_WR_B, row, col, $urandom_range(0, 1023));
      else             send_word(tmm_pkg::OP_NOP, row, col, $urandom_range(0, 1023));
    end
    no_gaps = 0;
    in_bus.valid <= 1'b0;

    wait (pending == 0);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d element writes and %0d tiles, %0d product words checked.",
             n_writes, n_tiles, results);
    $display("Included a full preload, corner tiles, nops and a long result stall.");
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
